// ===== rtl/ppsu_pkg.sv =====
// Shared constants and codes for the pure pursuit steering unit.
package ppsu_pkg;

  localparam int MAX_POINTS   = 256;
  localparam int CORDIC_STEPS = 16;
  localparam int IDX_W        = $clog2(MAX_POINTS);
  localparam int CNT_W        = IDX_W + 1;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);

  localparam logic [1:0] KIND_POSE    = 2'd0;
  localparam logic [1:0] KIND_POINT   = 2'd1;
  localparam logic [1:0] KIND_COMPUTE = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_GOAL  = 2'd2;

  localparam logic REG_LOOKAHEAD  = 1'b0;
  localparam logic REG_WHEEL_BASE = 1'b1;

  // squared goal radius, Q32
  localparam logic [64:0] GOAL_SQ  = 65'd4295;
  // 1/K of the CORDIC gain, Q30
  localparam logic [31:0] INV_GAIN = 32'd652032874;

  // atan(2^-k), pi = 2^31
  localparam logic [31:0] ATAN_TAB [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

endpackage

// ===== rtl/ppsu_cmd_if.sv =====
// Input item channel: pose, path point or compute request.
interface ppsu_cmd_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_y;
  logic signed [15:0] heading;

  modport source (output valid, kind, coord_x, coord_y, heading, input ready);
  modport sink   (input valid, kind, coord_x, coord_y, heading, output ready);
endinterface

// ===== rtl/ppsu_res_if.sv =====
// Result item channel: steering angle, target index and status.
interface ppsu_res_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] steer_angle;
  logic [7:0]         target_index;
  logic [1:0]         status;

  modport source (output valid, steer_angle, target_index, status, input ready);
  modport sink   (input valid, steer_angle, target_index, status, output ready);
endinterface

// ===== rtl/pure_pursuit_steering_unit.sv =====
// Pure pursuit steering unit: path store, nearest/lookahead search and CORDIC angle.
//
// cmd carries items of three kinds: a pose (x, y, heading), a path point that is
// appended to a 256-entry store (points past the last entry are dropped), and a
// compute request. Pose and point items are taken in S_IDLE, so a path can be
// loaded at one point per cycle while no compute runs. A compute request walks
// the store twice through one memory read port and one shared 35x32 multiplier,
// each point visited passing through S_RD, S_DIFF, S_SQX, S_SQY and S_ACC. Two
// 16-step CORDIC passes (rotate, then vector) run on one shared add/shift unit.
// cmd.ready is low for the whole compute. One result item goes out on res per
// compute request; the path is emptied after it. res is a held output register:
// while the receiver stalls, pose and point items are still taken, and a later
// compute waits for the register to drain. Reset (rst, synchronous) empties the
// path, zeroes the pose and sets both registers to 1.0 m. The APB port holds
// lookahead_dist at 0x0 and wheel_base at 0x4; write them only while idle.
module pure_pursuit_steering_unit (
  input  logic        clk,
  input  logic        rst,
  ppsu_cmd_if.sink    cmd,
  ppsu_res_if.source  res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [4:0] {
    S_IDLE, S_RD, S_DIFF, S_SQX, S_SQY, S_ACC, S_LD, S_LD2, S_GOAL,
    S_ROT, S_YM, S_YM2, S_NUM, S_NUM2, S_NORM, S_VEC, S_ANG, S_FIN
  } state_t;

  state_t state;

  logic [30:0] lookahead_dist, wheel_base;
  logic signed [31:0] pose_x, pose_y;
  logic signed [15:0] pose_heading;
  logic [ppsu_pkg::CNT_W-1:0] point_count;

  logic [31:0] mem_x [ppsu_pkg::MAX_POINTS];
  logic [31:0] mem_y [ppsu_pkg::MAX_POINTS];
  logic [31:0] rd_x, rd_y;

  logic [ppsu_pkg::IDX_W-1:0] idx, best;
  logic scan2;
  logic signed [32:0] dx, dy;
  logic [63:0] sq_x;
  logic [66:0] mul_p;
  logic [34:0] mul_a;
  logic [31:0] mul_b;
  logic [64:0] dmin, dcur, dn;
  logic [61:0] ld2;
  logic signed [63:0] cx, cy;
  logic signed [33:0] cz;
  logic [ppsu_pkg::STEP_W-1:0] k;
  logic yneg;
  logic [34:0] ymag;
  logic [66:0] num;

  logic signed [15:0] res_angle;
  logic [7:0] res_idx;
  logic [1:0] res_status;
  logic out_valid;
  logic signed [15:0] out_angle;
  logic [7:0] out_idx;
  logic [1:0] out_status;

  logic cmd_acc, cfg_wr;
  logic [64:0] dsum;
  logic last;
  logic [32:0] dx_abs, dy_abs;
  logic [63:0] cy_abs;
  logic signed [63:0] xs, ys, nx, ny;
  logic signed [33:0] at, nz;
  logic signed [33:0] zh, zi;
  logic signed [33:0] zr;
  logic signed [17:0] t;
  logic big;

  assign cmd_acc   = cmd.valid && cmd.ready;
  assign cmd.ready = (state == S_IDLE);
  assign cfg_wr    = psel && penable && pwrite;
  assign pready    = 1'b1;
  assign prdata    = {1'b0, (paddr[2] == ppsu_pkg::REG_WHEEL_BASE) ? wheel_base
                                                                  : lookahead_dist};

  assign res.valid        = out_valid;
  assign res.steer_angle  = out_angle;
  assign res.target_index = out_idx;
  assign res.status       = out_status;

  // path store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd_acc && cmd.kind == ppsu_pkg::KIND_POINT && !point_count[ppsu_pkg::CNT_W-1]) begin
      mem_x[point_count[ppsu_pkg::IDX_W-1:0]] <= cmd.coord_x;
      mem_y[point_count[ppsu_pkg::IDX_W-1:0]] <= cmd.coord_y;
    end
    rd_x <= mem_x[idx];
    rd_y <= mem_y[idx];
  end

  always_comb begin
    dx_abs = dx[32] ? -dx : dx;
    dy_abs = dy[32] ? -dy : dy;
    cy_abs = cy[63] ? -cy : cy;
    dsum   = {1'b0, sq_x} + {1'b0, mul_p[63:0]};
    last   = ({1'b0, idx} == point_count - ppsu_pkg::CNT_W'(1));
    big    = (num[66:60] != '0) || (dn[64:60] != '0);

    case (state)
      S_SQX:   begin mul_a = {3'b0, dx_abs[31:0]}; mul_b = dx_abs[31:0]; end
      S_SQY:   begin mul_a = {3'b0, dy_abs[31:0]}; mul_b = dy_abs[31:0]; end
      S_LD:    begin mul_a = {4'b0, lookahead_dist}; mul_b = {1'b0, lookahead_dist}; end
      S_YM:    begin mul_a = cy_abs[34:0]; mul_b = ppsu_pkg::INV_GAIN; end
      S_NUM:   begin mul_a = ymag; mul_b = {wheel_base, 1'b0}; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase

    // shared CORDIC add/shift unit
    xs = cx >>> k;
    ys = cy >>> k;
    at = 34'(ppsu_pkg::ATAN_TAB[{1'b0, k}]);
    nx = cx;
    ny = cy;
    nz = cz;
    if (state == S_ROT) begin
      if (!cz[33]) begin
        nx = cx - ys; ny = cy + xs; nz = cz - at;
      end else begin
        nx = cx + ys; ny = cy - xs; nz = cz + at;
      end
    end else if (cy > 0) begin
      nx = cx + ys; ny = cy - xs; nz = cz + at;
    end else if (cy < 0) begin
      nx = cx - ys; ny = cy + xs; nz = cz - at;
    end

    zh = {{2{pose_heading[15]}}, pose_heading, 16'b0};
    zi = -zh;
    zr = cz + 34'sd32768;
    t  = zr[33:16];
  end

  always_ff @(posedge clk) begin
    mul_p <= 67'(mul_a) * 67'(mul_b);

    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      point_count    <= '0;
      pose_x         <= '0;
      pose_y         <= '0;
      pose_heading   <= '0;
      lookahead_dist <= 31'd65536;
      wheel_base     <= 31'd65536;
    end else begin
      // S_FIN reloads the output register itself
      if (out_valid && res.ready && state != S_FIN) out_valid <= 1'b0;

      if (cfg_wr) begin
        if (paddr[2] == ppsu_pkg::REG_WHEEL_BASE) wheel_base <= pwdata[30:0];
        else lookahead_dist <= pwdata[30:0];
      end

      case (state)
        S_IDLE: begin
          if (cmd_acc) begin
            case (cmd.kind)
              ppsu_pkg::KIND_POSE: begin
                pose_x       <= cmd.coord_x;
                pose_y       <= cmd.coord_y;
                pose_heading <= cmd.heading;
              end
              ppsu_pkg::KIND_POINT: begin
                if (!point_count[ppsu_pkg::CNT_W-1]) point_count <= point_count + 1'b1;
              end
              ppsu_pkg::KIND_COMPUTE: begin
                idx   <= '0;
                scan2 <= 1'b0;
                if (point_count == '0) begin
                  res_angle  <= '0;
                  res_idx    <= '0;
                  res_status <= ppsu_pkg::STATUS_EMPTY;
                  state      <= S_FIN;
                end else begin
                  state <= S_RD;
                end
              end
              default: ;
            endcase
          end
        end
        S_RD: state <= S_DIFF;
        S_DIFF: begin
          dx    <= 33'($signed(rd_x)) - 33'(pose_x);
          dy    <= 33'($signed(rd_y)) - 33'(pose_y);
          state <= S_SQX;
        end
        S_SQX: state <= S_SQY;
        S_SQY: begin
          sq_x  <= mul_p[63:0];
          state <= S_ACC;
        end
        S_ACC: begin
          dcur <= dsum;
          if (!scan2) begin
            if (idx == '0 || dsum < dmin) begin
              dmin <= dsum;
              best <= idx;
            end
            if (last) state <= S_LD;
            else begin
              idx   <= idx + 1'b1;
              state <= S_RD;
            end
          end else if (dsum >= {3'b0, ld2} || last) begin
            state <= S_GOAL;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_RD;
          end
        end
        S_LD: state <= S_LD2;
        S_LD2: begin
          ld2   <= mul_p[61:0];
          idx   <= best;
          scan2 <= 1'b1;
          state <= S_RD;
        end
        S_GOAL: begin
          res_idx <= 8'(idx);
          k       <= '0;
          if (dcur < ppsu_pkg::GOAL_SQ) begin
            res_angle  <= '0;
            res_status <= ppsu_pkg::STATUS_GOAL;
            state      <= S_FIN;
          end else begin
            // turn by pi first when the angle lies outside +-pi/2
            if (zi > 34'sd1073741824) begin
              cx <= -64'(dx); cy <= -64'(dy); cz <= zi - 34'sd2147483648;
            end else if (zi < -34'sd1073741824) begin
              cx <= -64'(dx); cy <= -64'(dy); cz <= zi + 34'sd2147483648;
            end else begin
              cx <= 64'(dx); cy <= 64'(dy); cz <= zi;
            end
            state <= S_ROT;
          end
        end
        S_ROT, S_VEC: begin
          cx <= nx;
          cy <= ny;
          cz <= nz;
          k  <= k + 1'b1;
          if (k == ppsu_pkg::STEP_W'(ppsu_pkg::CORDIC_STEPS - 1))
            state <= (state == S_ROT) ? S_YM : S_ANG;
        end
        S_YM: begin
          yneg  <= cy[63];
          state <= S_YM2;
        end
        S_YM2: begin
          ymag  <= mul_p[64:30];
          state <= S_NUM;
        end
        S_NUM: state <= S_NUM2;
        S_NUM2: begin
          num   <= mul_p;
          dn    <= dcur;
          state <= S_NORM;
        end
        S_NORM: begin
          if (big) begin
            num <= num >> 1;
            dn  <= dn >> 1;
          end else begin
            cx    <= {4'b0, dn[59:0]};
            cy    <= yneg ? -{4'b0, num[59:0]} : {4'b0, num[59:0]};
            cz    <= '0;
            k     <= '0;
            state <= S_VEC;
          end
        end
        S_ANG: begin
          if (t > 18'sd16384) res_angle <= 16'sd16384;
          else if (t < -18'sd16384) res_angle <= -16'sd16384;
          else res_angle <= t[15:0];
          res_status <= ppsu_pkg::STATUS_OK;
          state      <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || res.ready) begin
            out_valid   <= 1'b1;
            out_angle   <= res_angle;
            out_idx     <= res_idx;
            out_status  <= res_status;
            point_count <= '0;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
